FILE: rtl/kse_pkg.sv
// Shared constants and types for the key sort engine.
package kse_pkg;

  localparam int unsigned DEF_CAPACITY  = 64;
  localparam int unsigned DEF_KEY_WIDTH = 32;
  localparam int unsigned KEY_PORT_W    = 32;

  typedef enum logic [3:0] {
    ST_LOAD   = 4'b0001,
    ST_DRAIN  = 4'b0010,
    ST_ROTATE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift;   // move contents one cell toward the head
    logic rotate;  // shift, with the head word wrapping to the tail
  } cell_ctrl_t;

endpackage

FILE: rtl/key_sort_engine.sv
// Key sort engine: loads a set of keys, then returns them in ascending order.
// Load: one key per cycle, accepted back to back; the set closes on last.
// After the closing key the chain settles, then in signed mode it is rotated,
// then N results are returned at one per cycle unless out_stall_i holds them
// (N = keys stored); the insertion chain's ripple depth sets the settle time.
// Reset clears the chain, count, overflow flag, signed mode and output stage.
module key_sort_engine #(
  parameter int unsigned CAPACITY  = kse_pkg::DEF_CAPACITY,
  parameter int unsigned KEY_WIDTH = kse_pkg::DEF_KEY_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [kse_pkg::KEY_PORT_W-1:0]   key_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [kse_pkg::KEY_PORT_W-1:0]   sorted_key_o,
  output logic                             last_out_o,
  output logic                             truncated_o
);
  import kse_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);
  localparam logic [CntW-1:0] OneCnt = CntW'(1);

  state_e          state_q, state_d;
  logic            signed_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rot_q, rot_d;
  logic            ovf_q, ovf_d;

  logic                 out_v_q, out_v_d;
  logic [KEY_WIDTH-1:0] out_k_q, out_k_d;
  logic                 out_l_q, out_l_d;
  logic                 out_t_q, out_t_d;

  logic [CAPACITY-1:0]  cell_v;
  logic [CAPACITY-1:0]  pass_v;
  logic [KEY_WIDTH-1:0] cell_k [CAPACITY];
  logic [KEY_WIDTH-1:0] pass_k [CAPACITY];

  cell_ctrl_t           ctrl;
  logic                 in_acc, ins_v, busy, take;
  logic [KEY_WIDTH-1:0] key_in;

  assign key_in     = KEY_WIDTH'({{KEY_WIDTH{1'b0}}, key_i});
  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ins_v      = in_acc && (cnt_q != CapCnt);
  assign busy       = |pass_v;
  assign take       = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_q <= 1'b0;
    end else if (cfg_we_i) begin
      signed_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rot_d       = rot_q;
    ovf_d       = ovf_q;
    ctrl.shift  = 1'b0;
    ctrl.rotate = 1'b0;
    out_v_d     = out_v_q && out_stall_i;
    out_k_d     = out_k_q;
    out_l_d     = out_l_q;
    out_t_d     = out_t_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (ins_v) begin
            cnt_d = cnt_q + OneCnt;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        rot_d = '0;
        if (!busy) begin
          state_d = signed_q ? ST_ROTATE : ST_EMIT;
        end
      end
      ST_ROTATE: begin
        // move nonnegative keys behind the negative ones
        if (cell_k[0][KEY_WIDTH-1] || (rot_q == cnt_q)) begin
          state_d = ST_EMIT;
        end else begin
          ctrl.rotate = 1'b1;
          rot_d       = rot_q + OneCnt;
        end
      end
      ST_EMIT: begin
        if (take) begin
          ctrl.shift = 1'b1;
          out_v_d    = 1'b1;
          out_k_d    = cell_k[0];
          out_l_d    = (cnt_q == OneCnt);
          out_t_d    = ovf_q;
          cnt_d      = cnt_q - OneCnt;
          if (cnt_q == OneCnt) begin
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      rot_q   <= '0;
      ovf_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rot_q   <= rot_d;
      ovf_q   <= ovf_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_k_q <= out_k_d;
    out_l_q <= out_l_d;
    out_t_q <= out_t_d;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 pin_v, rgt_v;
    logic [KEY_WIDTH-1:0] pin_k, rgt_k;
    if (i == 0) begin : g_head
      assign pin_v = ins_v;
      assign pin_k = key_in;
    end else begin : g_body
      assign pin_v = pass_v[i-1];
      assign pin_k = pass_k[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rgt_v = 1'b0;
      assign rgt_k = '0;
    end else begin : g_next
      assign rgt_v = cell_v[i+1];
      assign rgt_k = cell_k[i+1];
    end
    kse_cell #(
      .KeyWidth(KEY_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .pass_valid_i (pin_v),
      .pass_key_i   (pin_k),
      .right_valid_i(rgt_v),
      .right_key_i  (rgt_k),
      .head_key_i   (cell_k[0]),
      .valid_o      (cell_v[i]),
      .key_o        (cell_k[i]),
      .pass_valid_o (pass_v[i]),
      .pass_key_o   (pass_k[i])
    );
  end

  assign out_valid_o  = out_v_q;
  assign sorted_key_o = KEY_PORT_W'({{KEY_PORT_W{1'b0}}, out_k_q});
  assign last_out_o   = out_l_q;
  assign truncated_o  = out_t_q;

  a_emit_head_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> cell_v[0])
    else $error("emitting from an empty chain");

  a_emit_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> $countones(cell_v) == int'(cnt_q))
    else $error("occupied cells disagree with key count");

  a_settled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROTATE || state_q == ST_EMIT) |-> !busy)
    else $error("words still rippling after drain");

  a_rot_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROTATE |-> rot_q <= cnt_q)
    else $error("rotation ran past key count");

endmodule

FILE: rtl/kse_cell.sv
// One cell of the systolic sort chain: holds one key and a pass-down register.
module kse_cell #(
  parameter int unsigned KeyWidth = kse_pkg::DEF_KEY_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kse_pkg::cell_ctrl_t ctrl_i,
  input  logic                pass_valid_i,
  input  logic [KeyWidth-1:0] pass_key_i,
  input  logic                right_valid_i,
  input  logic [KeyWidth-1:0] right_key_i,
  input  logic [KeyWidth-1:0] head_key_i,
  output logic                valid_o,
  output logic [KeyWidth-1:0] key_o,
  output logic                pass_valid_o,
  output logic [KeyWidth-1:0] pass_key_o
);
  import kse_pkg::*;

  logic                valid_q, valid_d;
  logic [KeyWidth-1:0] key_q, key_d;
  logic                pv_q, pv_d;
  logic [KeyWidth-1:0] pk_q, pk_d;

  // chain is kept in unsigned order; signed order is a rotation of it
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    pv_d    = 1'b0;
    pk_d    = pk_q;
    if (ctrl_i.rotate) begin
      if (valid_q) begin
        key_d = right_valid_i ? right_key_i : head_key_i;
      end
    end else if (ctrl_i.shift) begin
      valid_d = right_valid_i;
      key_d   = right_key_i;
    end else if (pass_valid_i) begin
      if (!valid_q) begin
        valid_d = 1'b1;
        key_d   = pass_key_i;
      end else if (pass_key_i < key_q) begin
        key_d = pass_key_i;
        pv_d  = 1'b1;
        pk_d  = key_q;
      end else begin
        pv_d = 1'b1;
        pk_d = pass_key_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pv_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pv_q    <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pk_q  <= pk_d;
  end

  assign valid_o      = valid_q;
  assign key_o        = key_q;
  assign pass_valid_o = pv_q;
  assign pass_key_o   = pk_q;

endmodule
